// ===== src/alt_screen_escape_stripper_macros.svh =====
// Assertion macros for the alternate-screen escape stripper.
// No dependencies; included by the checker file.
`ifndef ALT_SCREEN_ESCAPE_STRIPPER_MACROS_SVH
`define ALT_SCREEN_ESCAPE_STRIPPER_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASESC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define ASESC_ASSERT(lbl, prop, msg) `ASESC_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/asesc_pkg.sv =====
// Shared types, codes and the digit matcher for the escape stripper.
// No dependencies; used by every module of the block.
package asesc_pkg;

  localparam int unsigned HOLD_DEPTH = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CNT_W      = 4;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_QMARK    = 8'h3F;
  localparam logic [7:0] CH_H        = 8'h68;
  localparam logic [7:0] CH_L        = 8'h6C;
  localparam logic [7:0] CH_0        = 8'h30;
  localparam logic [7:0] CH_1        = 8'h31;
  localparam logic [7:0] CH_4        = 8'h34;
  localparam logic [7:0] CH_7        = 8'h37;
  localparam logic [7:0] CH_9        = 8'h39;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } asesc_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       alt_active;
  } asesc_out_t;

  // Parser phase
  typedef enum logic [5:0] {
    PH_NORMAL  = 6'b000001,
    PH_ESC     = 6'b000010,
    PH_BRACKET = 6'b000100,
    PH_QM      = 6'b001000,
    PH_INT     = 6'b010000,
    PH_DRAIN   = 6'b100000
  } phase_e;

  // Digit prefix matched so far
  typedef enum logic [2:0] {
    DM_NONE = 3'd0,
    DM_1    = 3'd1,
    DM_10   = 3'd2,
    DM_104  = 3'd3,
    DM_1049 = 3'd4,
    DM_1047 = 3'd5,
    DM_4    = 3'd6,
    DM_47   = 3'd7
  } digit_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } ctrl_state_e;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             drain;
    logic [IDX_W-1:0] rd_idx;
    logic             last;
  } asesc_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] rel_n;
  } asesc_sts_t;

  function automatic digit_e advance_digits(input digit_e m, input logic [7:0] b);
    digit_e r;
    r = DM_NONE;
    case (m)
      DM_NONE: begin
        if (b == CH_1) r = DM_1;
        else if (b == CH_4) r = DM_4;
      end
      DM_1:   if (b == CH_0) r = DM_10;
      DM_10:  if (b == CH_4) r = DM_104;
      DM_104: begin
        if (b == CH_9) r = DM_1049;
        else if (b == CH_7) r = DM_1047;
      end
      DM_4:   if (b == CH_7) r = DM_47;
      default: r = DM_NONE;
    endcase
    return r;
  endfunction

endpackage

// ===== src/alt_screen_escape_stripper.sv =====
// Top level of the alternate-screen escape stripper.
// Depends on asesc_pkg, asesc_ctrl and asesc_datapath.
//
//   channel | direction | handshake               | payload
//   in      | sink      | in_valid_i / in_stall_o  | asesc_in_t  (in_byte, chunk_end)
//   out     | source    | out_valid_o / out_stall_i| asesc_out_t (out_byte, has_byte,
//           |           |                          |   run_last, alt_active)
//
// An item gives 1 to 8 results, which leave the output register as one run; plain text
// runs at one byte per cycle while the output is unstalled. The held bytes sit in an
// eight-entry register buffer and a released sequence drains one byte a cycle, while the
// output is unstalled, with input stalled.
// Reset clears parser phase, digit match, fill count and alt flag; held bytes are not.
// A stalled output holds its transaction; input is taken whenever no release is draining
// and the output register is free or being emptied in the same cycle.
module alt_screen_escape_stripper (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  asesc_pkg::asesc_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output asesc_pkg::asesc_out_t out_data_o
);
  import asesc_pkg::*;

  asesc_cmd_t cmd;
  asesc_sts_t sts;

  asesc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  asesc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/asesc_datapath.sv =====
// Datapath of the escape stripper: parser state, held-byte buffer, output register.
// Depends on asesc_pkg; driven by asesc_ctrl through command and status structs.
module asesc_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  asesc_pkg::asesc_in_t  in_data_i,
  input  asesc_pkg::asesc_cmd_t cmd_i,
  output asesc_pkg::asesc_sts_t sts_o,
  output asesc_pkg::asesc_out_t out_data_o
);
  import asesc_pkg::*;

  phase_e           phase_q, phase_d;
  digit_e           dm_q, dm_d, dm_adv;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             alt_q, alt_d;
  logic [7:0]       buf_q [HOLD_DEPTH];
  asesc_out_t       out_q, out_d;

  logic [7:0]       b;
  logic             is_dig;
  logic             hold_c;
  logic             emit_all;
  logic [CNT_W-1:0] emit_n;
  logic [CNT_W-1:0] rel_n;

  assign b      = in_data_i.in_byte;
  assign is_dig = (b >= CH_0) && (b <= CH_9);
  assign dm_adv = advance_digits((phase_q == PH_QM) ? DM_NONE : dm_q, b);

  always_comb begin
    phase_d  = phase_q;
    dm_d     = dm_q;
    alt_d    = alt_q;
    hold_c   = 1'b0;
    emit_all = 1'b0;
    case (phase_q)
      PH_ESC: begin
        if (b == CH_LBRACKET) begin
          hold_c  = 1'b1;
          phase_d = PH_BRACKET;
        end else begin
          emit_all = 1'b1;
          dm_d     = DM_NONE;
          phase_d  = PH_NORMAL;
        end
      end
      PH_BRACKET: begin
        if (b == CH_QMARK) begin
          hold_c  = 1'b1;
          phase_d = PH_QM;
        end else begin
          emit_all = 1'b1;
          dm_d     = DM_NONE;
          phase_d  = PH_NORMAL;
        end
      end
      PH_QM, PH_INT: begin
        if (is_dig) begin
          if (dm_adv == DM_NONE) begin
            // prefix can no longer match: release and pass remaining digits
            emit_all = 1'b1;
            dm_d     = DM_NONE;
            phase_d  = PH_DRAIN;
          end else begin
            hold_c  = 1'b1;
            dm_d    = dm_adv;
            phase_d = PH_INT;
          end
        end else if ((phase_q == PH_INT) && ((b == CH_H) || (b == CH_L)) &&
                     ((dm_q == DM_1049) || (dm_q == DM_1047) || (dm_q == DM_47))) begin
          // supported sequence: strip it and update the flag
          alt_d   = (b == CH_H);
          dm_d    = DM_NONE;
          phase_d = PH_NORMAL;
        end else begin
          emit_all = 1'b1;
          dm_d     = DM_NONE;
          phase_d  = PH_NORMAL;
        end
      end
      PH_DRAIN: begin
        emit_all = 1'b1;
        if (!is_dig) begin
          dm_d    = DM_NONE;
          phase_d = PH_NORMAL;
        end
      end
      default: begin
        phase_d = PH_NORMAL;
        if (b == CH_ESC) begin
          hold_c  = 1'b1;
          phase_d = PH_ESC;
        end else begin
          emit_all = 1'b1;
        end
      end
    endcase

    // chunk end: flush a partial sequence and return to plain text
    if (in_data_i.chunk_end) begin
      if ((phase_d == PH_ESC) || (phase_d == PH_BRACKET) ||
          (phase_d == PH_QM) || (phase_d == PH_INT)) begin
        emit_all = 1'b1;
      end
      hold_c  = 1'b0;
      dm_d    = DM_NONE;
      phase_d = PH_NORMAL;
    end
  end

  // the current byte always lands at the fill position, so a release is buf[0..cnt]
  assign emit_n = {1'b0, cnt_q} + CNT_W'(1);
  assign rel_n  = (emit_all && !alt_q) ? emit_n : '0;
  assign cnt_d  = hold_c ? (cnt_q + IDX_W'(1)) : '0;

  assign sts_o.rel_n = rel_n;

  always_comb begin
    out_d = out_q;
    if (cmd_i.load) begin
      if (cmd_i.drain) begin
        out_d.out_byte   = buf_q[cmd_i.rd_idx];
        out_d.has_byte   = 1'b1;
        out_d.run_last   = cmd_i.last;
        out_d.alt_active = alt_q;
      end else begin
        out_d.has_byte   = (rel_n != '0);
        out_d.run_last   = (rel_n <= CNT_W'(1));
        out_d.alt_active = alt_d;
        if (rel_n == '0) out_d.out_byte = 8'd0;
        else if (cnt_q == '0) out_d.out_byte = b;
        else out_d.out_byte = buf_q[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      dm_q    <= DM_NONE;
      cnt_q   <= '0;
      alt_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      phase_q <= phase_d;
      dm_q    <= dm_d;
      cnt_q   <= cnt_d;
      alt_q   <= alt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) buf_q[cnt_q] <= b;
    out_q <= out_d;
  end

  assign out_data_o = out_q;

endmodule

// ===== src/asesc_ctrl.sv =====
// Controller of the escape stripper: handshakes and the release sequencer.
// Depends on asesc_pkg; commands asesc_datapath.
module asesc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  asesc_pkg::asesc_sts_t sts_i,
  output asesc_pkg::asesc_cmd_t cmd_o
);
  import asesc_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             drain_last;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign drain_last = (({1'b0, idx_q} + CNT_W'(1)) == n_q);

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    n_d          = n_q;
    cmd_o        = '0;
    cmd_o.rd_idx = idx_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && out_free) begin
          cmd_o.accept = 1'b1;
          cmd_o.load   = 1'b1;
          // first byte goes out now; sequence the rest of the release
          if (sts_i.rel_n > CNT_W'(1)) begin
            state_d = ST_DRAIN;
            idx_d   = IDX_W'(1);
            n_d     = sts_i.rel_n;
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.drain = 1'b1;
          cmd_o.last  = drain_last;
          if (drain_last) state_d = ST_IDLE;
          else idx_d = idx_q + IDX_W'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/asesc_checker.sv =====
// Port-level checks for the escape stripper, bound to the top level.
// Depends on asesc_pkg and alt_screen_escape_stripper_macros.svh.
`include "alt_screen_escape_stripper_macros.svh"

module asesc_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input asesc_pkg::asesc_out_t out_data_o
);
  import asesc_pkg::*;

  // a stalled result transaction must hold
  `ASESC_ASSERT(a_out_hold,
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o),
    "stalled result changed")

  `ASESC_ASSERT(a_status_only,
    out_valid_o && !out_data_o.has_byte |-> out_data_o.run_last &&
      (out_data_o.out_byte == 8'd0),
    "status-only result malformed")

  // input must wait until a multi-result run is fully delivered
  `ASESC_ASSERT(a_run_blocks_in,
    out_valid_o && !out_data_o.run_last |-> in_stall_o,
    "input taken mid run")

  `ASESC_ASSERT(a_alt_silent,
    out_valid_o && out_data_o.alt_active |-> !out_data_o.has_byte,
    "byte released on alternate screen")

  // a run continues without gaps and with one flag value
  `ASESC_ASSERT(a_run_continues,
    out_valid_o && !out_stall_i && !out_data_o.run_last |=>
      out_valid_o && $stable(out_data_o.alt_active),
    "run broken")

endmodule

bind alt_screen_escape_stripper asesc_checker u_asesc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
